/* src/clad_pkg.sv */
// Shared types and constants for the circular list block.
// No dependencies; imported by every module of the block.
`default_nettype none

package clad_pkg;

    localparam int CAPACITY_DEFAULT = 32;
    localparam int DATA_W           = 32;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_DELETE = 2'd1,
        OP_DUMP   = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // One result item as produced by the sequencer, before the output register.
    typedef struct packed {
        logic                valid;
        status_t             status;
        logic [DATA_W-1:0]   value;
        logic                last;
    } result_t;

endpackage

`default_nettype wire

/* src/clad_store.sv */
// Entry storage: one write port and one read port with registered read data.
// Depends on clad_pkg for the data width.
`default_nettype none

module clad_store #(
    parameter int DEPTH = clad_pkg::CAPACITY_DEFAULT,
    parameter int AW    = 5
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [AW-1:0]              waddr,
    input  wire logic [clad_pkg::DATA_W-1:0] wdata,
    input  wire logic                       re,
    input  wire logic [AW-1:0]              raddr,
    output logic      [clad_pkg::DATA_W-1:0] rdata
);
    import clad_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* src/clad_walker.sv */
// Sequencer that walks the entry store one entry per cycle with a shared compare.
// Depends on clad_pkg; drives the clad_store ports and produces result items.
`default_nettype none

module clad_walker #(
    parameter int CAPACITY = clad_pkg::CAPACITY_DEFAULT,
    parameter int AW       = 5,
    parameter int CW       = 6
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [1:0]                  opcode,
    input  wire logic [clad_pkg::DATA_W-1:0] operand_value,
    output logic                             busy,
    output logic                             mem_we,
    output logic [AW-1:0]                    mem_waddr,
    output logic [clad_pkg::DATA_W-1:0]      mem_wdata,
    output logic                             mem_re,
    output logic [AW-1:0]                    mem_raddr,
    input  wire logic [clad_pkg::DATA_W-1:0] mem_rdata,
    output clad_pkg::result_t                res,
    output logic [CW-1:0]                    res_count
);
    import clad_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DELETE = 3'b010,
        S_DUMP   = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [DATA_W-1:0] key_reg, key_next;
    logic              found_reg, found_next;

    logic              issue;
    logic              is_last;
    logic              match;

    // The read pointer runs one ahead of the index whose data is in mem_rdata.
    assign issue   = (ptr_reg < count_reg);
    assign is_last = (CW'(idx_reg) == (count_reg - CW'(1)));
    assign match   = (mem_rdata == key_reg);
    assign busy    = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        idx_next   = idx_reg;
        key_next   = key_reg;
        found_next = found_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg - AW'(1);
        mem_wdata  = mem_rdata;
        mem_re     = 1'b0;
        mem_raddr  = ptr_reg[AW-1:0];
        res        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (opcode)
                        OP_APPEND:
                        begin
                            res.valid = 1'b1;
                            res.last  = 1'b1;
                            if (count_reg == CW'(CAPACITY))
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[AW-1:0];
                                mem_wdata  = operand_value;
                                count_next = count_reg + CW'(1);
                                res.status = ST_OK;
                            end
                        end
                        OP_DELETE, OP_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                res.valid  = 1'b1;
                                res.last   = 1'b1;
                                res.status = (opcode == OP_DELETE) ? ST_NOTFOUND : ST_EMPTY;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = '0;
                                ptr_next   = CW'(1);
                                idx_next   = '0;
                                key_next   = operand_value;
                                found_next = 1'b0;
                                state_next = (opcode == OP_DELETE) ? S_DELETE : S_DUMP;
                            end
                        end
                        default:
                        begin
                            // An unknown opcode leaves the list alone and gives no result.
                        end
                    endcase
                end
            end
            S_DELETE:
            begin
                mem_re   = issue;
                ptr_next = issue ? ptr_reg + CW'(1) : ptr_reg;
                idx_next = idx_reg + AW'(1);
                if (found_reg)
                begin
                    // Close the gap: every entry after the match moves one place down.
                    mem_we = 1'b1;
                end
                else if (match)
                begin
                    found_next = 1'b1;
                end
                if (is_last)
                begin
                    res.valid  = 1'b1;
                    res.last   = 1'b1;
                    res.status = (found_reg || match) ? ST_OK : ST_NOTFOUND;
                    if (found_reg || match)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            S_DUMP:
            begin
                mem_re     = issue;
                ptr_next   = issue ? ptr_reg + CW'(1) : ptr_reg;
                idx_next   = idx_reg + AW'(1);
                res.valid  = 1'b1;
                res.status = ST_OK;
                res.value  = mem_rdata;
                res.last   = is_last;
                if (is_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_count = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

`default_nettype wire

/* src/circular_list_append_delete.sv */
// Top level of the bounded ordered list: output register around the walker and store.
// Depends on clad_pkg, clad_store and clad_walker.
//
// Usage: an item (opcode, operand_value) is taken at a rising edge where start is
// high and busy is low. Results appear on status, entry_value, entry_count and
// last_of_run for exactly one cycle, marked by strobe; the receiver cannot stall.
// last_of_run marks the final result of each item.
// Behaviour per item:
//   append (ok or full), delete or dump on an empty list: one result, registered in the
//   cycle after acceptance; busy stays low, so a new item can follow at once.
//   delete: walks the list one entry per cycle through the single read port and
//   the shared comparator, busy while it walks the N entries held; the result
//   strobe rises in the same cycle as busy falls.
//   dump: one result per cycle, one per entry held, the first passing through the
//   store read register and then the output register.
// An unknown opcode produces no result and changes nothing.
// Reset empties the list; the store contents are not cleared, as entries are
// only read below the fill count.
`default_nettype none

module circular_list_append_delete #(
    parameter int CAPACITY = clad_pkg::CAPACITY_DEFAULT,
    parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [1:0]                         opcode,
    input  wire logic signed [clad_pkg::DATA_W-1:0] operand_value,
    output logic                                    strobe,
    output logic [1:0]                              status,
    output logic signed [clad_pkg::DATA_W-1:0]      entry_value,
    output logic [CW-1:0]                           entry_count,
    output logic                                    last_of_run
);
    import clad_pkg::*;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;
    result_t           res;
    logic [CW-1:0]     res_count;

    logic              strobe_reg;
    status_t           status_reg;
    logic [DATA_W-1:0] value_reg;
    logic [CW-1:0]     count_reg;
    logic              last_reg;

    clad_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    clad_walker #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_walker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .opcode        (opcode),
        .operand_value (operand_value),
        .busy          (busy),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_re        (mem_re),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata),
        .res           (res),
        .res_count     (res_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            status_reg <= res.status;
            value_reg  <= res.value;
            count_reg  <= res_count;
            last_reg   <= res.last;
        end
    end

    assign strobe      = strobe_reg;
    assign status      = status_reg;
    assign entry_value = value_reg;
    assign entry_count = count_reg;
    assign last_of_run = last_reg;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the bounded ordered list (append, delete, dump).
// Depends on clad_pkg and the circular_list_append_delete top level; a queued
// driver feeds items and a clocked monitor checks each result against a predictor.

module tb_top;

    import clad_pkg::*;

    localparam int CAPACITY  = CAPACITY_DEFAULT;
    localparam int CW        = $clog2(CAPACITY + 1);
    localparam int RAND_ITEMS = 220;

    // Opcode 3 has no meaning; the block must swallow it without a result.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

    localparam int PH_FILL  = 0;
    localparam int PH_DRAIN = 1;
    localparam int PH_MIXED = 2;

    typedef struct {
        logic [1:0]               op;
        logic signed [DATA_W-1:0] val;
    } list_cmd_t;

    typedef struct {
        status_t                  status;
        logic signed [DATA_W-1:0] value;
        logic [CW-1:0]            count;
        logic                     last;
    } list_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               opcode;
    logic signed [DATA_W-1:0] operand_value;
    logic                     strobe;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] entry_value;
    logic [CW-1:0]            entry_count;
    logic                     last_of_run;

    list_cmd_t                pending_items[$];
    list_result_t             expected_results[$];
    logic signed [DATA_W-1:0] held_values[$];
    logic signed [DATA_W-1:0] planned_values[$];

    bit took_item;
    int idle_left;
    int burst_left;
    int error_count;
    int accepted_items;
    int checked_results;
    int dropped_appends;
    int missed_deletes;
    int dumps_seen;

    circular_list_append_delete #(
        .CAPACITY(CAPACITY)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .operand_value(operand_value),
        .strobe       (strobe),
        .status       (status),
        .entry_value  (entry_value),
        .entry_count  (entry_count),
        .last_of_run  (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%s", msg);
    endtask

    task automatic push_result(input status_t st, input logic signed [DATA_W-1:0] v,
                               input logic last);
        list_result_t res;
        res.status = st;
        res.value  = v;
        res.count  = CW'(held_values.size());
        res.last   = last;
        expected_results.push_back(res);
    endtask

    // Applies one accepted item to the predicted list and queues its results.
    task automatic predict_list_op(input logic [1:0] op, input logic signed [DATA_W-1:0] key);
        int idx;
        idx = -1;
        case (op)
            OP_APPEND:
            begin
                if (held_values.size() >= CAPACITY)
                begin
                    dropped_appends++;
                    push_result(ST_FULL, '0, 1'b1);
                end
                else
                begin
                    held_values.push_back(key);
                    push_result(ST_OK, '0, 1'b1);
                end
            end
            OP_DELETE:
            begin
                foreach (held_values[i])
                    if (idx < 0 && held_values[i] === key)
                        idx = i;
                if (idx >= 0)
                begin
                    held_values.delete(idx);
                    push_result(ST_OK, '0, 1'b1);
                end
                else
                begin
                    missed_deletes++;
                    push_result(ST_NOTFOUND, '0, 1'b1);
                end
            end
            OP_DUMP:
            begin
                dumps_seen++;
                if (held_values.size() == 0)
                    push_result(ST_EMPTY, '0, 1'b1);
                else
                    foreach (held_values[i])
                        push_result(ST_OK, held_values[i], i == held_values.size() - 1);
            end
            default:
            begin
            end
        endcase
    endtask

    // Queues one item and tracks the list it will build, so that later deletes
    // can aim at values that are really held.
    task automatic add_item(input logic [1:0] op, input logic signed [DATA_W-1:0] v);
        list_cmd_t cmd;
        int idx;
        cmd.op  = op;
        cmd.val = v;
        idx     = -1;
        pending_items.push_back(cmd);
        if (op == OP_APPEND && planned_values.size() < CAPACITY)
            planned_values.push_back(v);
        else if (op == OP_DELETE)
        begin
            foreach (planned_values[i])
                if (idx < 0 && planned_values[i] === v)
                    idx = i;
            if (idx >= 0)
                planned_values.delete(idx);
        end
    endtask

    // Driver: inputs change on the falling edge only.
    always @(negedge clk)
    begin : drive_proc
        logic      next_start;
        list_cmd_t cmd;
        if (rst_n)
        begin
            next_start = start;
            if (took_item)
            begin
                took_item  = 1'b0;
                next_start = 1'b0;
                if (burst_left > 0)
                begin
                    burst_left--;
                    idle_left = 0;
                end
                else
                begin
                    if ($urandom_range(0, 7) == 0)
                        burst_left = $urandom_range(10, 30);
                    idle_left = $urandom_range(0, 4);
                end
            end
            if (!next_start)
            begin
                if (idle_left > 0)
                    idle_left--;
                else if (pending_items.size() > 0)
                begin
                    cmd = pending_items.pop_front();
                    opcode        <= cmd.op;
                    operand_value <= cmd.val;
                    next_start    = 1'b1;
                end
            end
            start <= next_start;
        end
    end

    // Monitor: results and acceptance are sampled on the rising edge.
    always @(posedge clk)
    begin : monitor_proc
        list_result_t want;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (expected_results.size() == 0)
                    note_failure($sformatf("unexpected result: status %0d value %0d count %0d last %0b",
                                           status, entry_value, entry_count, last_of_run));
                else
                begin
                    want = expected_results.pop_front();
                    checked_results++;
                    if (status !== want.status || entry_value !== want.value ||
                        entry_count !== want.count || last_of_run !== want.last)
                        note_failure($sformatf(
                            "mismatch: expected status %0d value %0d count %0d last %0b, got status %0d value %0d count %0d last %0b",
                            want.status, want.value, want.count, want.last,
                            status, entry_value, entry_count, last_of_run));
                end
            end
            if (start && !busy)
            begin
                predict_list_op(opcode, operand_value);
                accepted_items++;
                took_item = 1'b1;
            end
        end
    end

    initial
    begin
        #400000;
        $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        int         n;
        int         pick;
        int         phase_kind;
        logic [1:0] op;
        logic signed [DATA_W-1:0] val;

        rst_n         = 1'b0;
        start         = 1'b0;
        opcode        = OP_APPEND;
        operand_value = '0;
        took_item     = 1'b0;
        idle_left     = 0;
        burst_left    = 0;
        error_count   = 0;

        // Directed part: empty list cases, extremes, first match among duplicates,
        // removal at head, middle and tail, and the ignored opcode.
        add_item(OP_DUMP, 0);
        add_item(OP_DELETE, 5);
        add_item(OP_APPEND, VAL_MIN);
        add_item(OP_APPEND, VAL_MAX);
        add_item(OP_APPEND, 0);
        add_item(OP_APPEND, -1);
        add_item(OP_APPEND, VAL_MAX);
        add_item(OP_DUMP, 0);
        add_item(OP_DELETE, VAL_MAX);
        add_item(OP_DUMP, 0);
        add_item(OP_DELETE, 12345);
        add_item(OP_UNUSED, -1);
        add_item(OP_DELETE, VAL_MIN);
        add_item(OP_DELETE, VAL_MAX);
        add_item(OP_DELETE, -1);
        add_item(OP_DUMP, 0);
        add_item(OP_DELETE, 0);
        add_item(OP_DUMP, 0);
        add_item(OP_APPEND, 32'h5555_5555);
        add_item(OP_APPEND, 32'hAAAA_AAAA);
        add_item(OP_DUMP, 0);
        add_item(OP_UNUSED, 0);

        // Random part in phases: filling up past full, draining, and a mix.
        for (n = 0; n < RAND_ITEMS; n++)
        begin
            if (n < 50 || (n >= 140 && n < 190))
                phase_kind = PH_FILL;
            else if (n < 140 && n >= 100)
                phase_kind = PH_MIXED;
            else
                phase_kind = PH_DRAIN;
            pick = $urandom_range(0, 99);
            if (pick < 3)
                op = OP_UNUSED;
            else if (pick < 11)
                op = OP_DUMP;
            else if ((phase_kind == PH_FILL && pick < 93) ||
                     (phase_kind == PH_DRAIN && pick < 26) ||
                     (phase_kind == PH_MIXED && pick < 56))
                op = OP_APPEND;
            else
                op = OP_DELETE;
            if (op == OP_DELETE && planned_values.size() > 0 && $urandom_range(0, 3) != 0)
                val = planned_values[$urandom_range(0, planned_values.size() - 1)];
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    val = VAL_MIN;
                else if (pick == 1)
                    val = VAL_MAX;
                else if (pick < 6)
                    val = $urandom_range(0, 4) - 2;
                else
                    val = $urandom;
            end
            add_item(op, val);
        end

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || start)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (CAPACITY + 8) @(posedge clk);

        if (expected_results.size() != 0)
            note_failure($sformatf("%0d expected results never arrived",
                                   expected_results.size()));

        $display("Covered %0d items (%0d dumps, %0d appends dropped when full, %0d deletes without match).",
                 accepted_items, dumps_seen, dropped_appends, missed_deletes);
        $display("Checked %0d results, %0d failures.", checked_results, error_count);
        if (error_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

/* sim.f */
src/clad_pkg.sv
src/clad_store.sv
src/clad_walker.sv
src/circular_list_append_delete.sv
sim/tb_top.sv
